// ===== sv/ledblk_pkg.sv =====
// Shared types and constants for the LED blink controller.
`default_nettype none

package ledblk_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int TIME_W           = 16;
    localparam int COUNT_W          = 8;

    typedef enum logic [1:0] {
        KIND_LEVEL = 2'd0,
        KIND_BLINK = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic                level_on;
        logic [TIME_W-1:0]   on_time_ms;
        logic [TIME_W-1:0]   off_time_ms;
        logic [COUNT_W-1:0]  cycle_count;
    } ledblk_cmd_t;

endpackage

`default_nettype wire

// ===== sv/ledblk_req_if.sv =====
// Command channel: valid/ready handshake with one command item.
`default_nettype none

interface ledblk_req_if
    import ledblk_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
);
    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [CHANNELS-1:0] channel_mask;
    logic                level_on;
    logic [TIME_W-1:0]   on_time_ms;
    logic [TIME_W-1:0]   off_time_ms;
    logic [COUNT_W-1:0]  cycle_count;

    modport source (
        output valid, kind, channel_mask, level_on, on_time_ms, off_time_ms, cycle_count,
        input  ready
    );

    modport sink (
        input  valid, kind, channel_mask, level_on, on_time_ms, off_time_ms, cycle_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/ledblk_rsp_if.sv =====
// Result channel: valid/ready handshake with the LED state item.
`default_nettype none

interface ledblk_rsp_if
    import ledblk_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
);
    logic                valid;
    logic                ready;
    logic [CHANNELS-1:0] led_bits;

    modport source (
        output valid, led_bits,
        input  ready
    );

    modport sink (
        input  valid, led_bits,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/ledblk_channel.sv =====
// One LED channel: level, blink timer, phase and cycle counter.
`default_nettype none

module ledblk_channel
    import ledblk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        enable,
    input  wire logic        sel,
    input  wire ledblk_cmd_t cmd,
    output logic             led,
    output logic             led_next
);

    logic               led_reg;
    logic               active_reg,  active_next;
    logic               phase_reg,   phase_next;
    logic               endless_reg, endless_next;
    logic [TIME_W-1:0]  on_reg,      on_next;
    logic [TIME_W-1:0]  off_reg,     off_next;
    logic [COUNT_W-1:0] left_reg,    left_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;

    logic [TIME_W-1:0]  elapsed_inc;
    logic [TIME_W-1:0]  interval;
    logic [COUNT_W-1:0] left_dec;

    always_comb
    begin
        elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TIME_W'(1);
        interval     = phase_reg ? on_reg : off_reg;
        left_dec     = (left_reg != '0) ? left_reg - COUNT_W'(1) : left_reg;

        led_next     = led_reg;
        active_next  = active_reg;
        phase_next   = phase_reg;
        endless_next = endless_reg;
        on_next      = on_reg;
        off_next     = off_reg;
        left_next    = left_reg;
        elapsed_next = elapsed_reg;

        if (enable)
        begin
            case (cmd.kind)
                KIND_LEVEL:
                begin
                    if (sel)
                    begin
                        active_next = 1'b0;
                        led_next    = cmd.level_on;
                    end
                end
                KIND_BLINK:
                begin
                    if (sel)
                    begin
                        on_next      = cmd.on_time_ms;
                        off_next     = cmd.off_time_ms;
                        left_next    = cmd.cycle_count;
                        endless_next = (cmd.cycle_count == '0);
                        elapsed_next = '0;
                        phase_next   = 1'b1;
                        active_next  = 1'b1;
                        led_next     = 1'b1;
                    end
                end
                KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        if (elapsed_inc >= interval)
                        begin
                            elapsed_next = '0;
                            phase_next   = !phase_reg;
                            led_next     = !phase_reg;
                            if (phase_reg && !endless_reg)
                            begin
                                left_next = left_dec;
                                if (left_dec == '0)
                                begin
                                    active_next = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg     <= 1'b0;
            active_reg  <= 1'b0;
            phase_reg   <= 1'b0;
            endless_reg <= 1'b0;
            on_reg      <= '0;
            off_reg     <= '0;
            left_reg    <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            led_reg     <= led_next;
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            endless_reg <= endless_next;
            on_reg      <= on_next;
            off_reg     <= off_next;
            left_reg    <= left_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign led = led_reg;

    // LED follows phase while blinking
    a_led_phase: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (led_reg == phase_reg))
        else $error("blinking channel LED differs from phase");

    // a counted blink never sits active with no cycles left
    a_counted_left: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !endless_reg) |-> (left_reg != '0))
        else $error("counted blink active with zero cycles left");

    // timer holds while not blinking and idle
    a_elapsed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!active_reg && !enable) |=> $stable(elapsed_reg))
        else $error("elapsed counter moved on an idle channel");

endmodule

`default_nettype wire

// ===== sv/four_channel_led_blinker_core.sv =====
// Top level of the LED blink controller: command register, channels, result register.
//
// Usage:
//   req carries one command item per handshake: kind selects set level, start
//   blink or a one millisecond tick; channel_mask picks the channels for level
//   and blink; level_on, on_time_ms, off_time_ms and cycle_count hold the
//   arguments. Every item yields exactly one item on rsp: led_bits, the LED
//   state after the command has been applied. Kind 3 changes nothing.
//   An accepted item is held in the command register; its result is then
//   registered in the result register and shown on rsp from there.
//   Throughput: one item per cycle while rsp is ready; all channels update in
//   parallel, in the same cycle as the result register is loaded.
//   Stall: while rsp is held, the result register keeps its item, the command
//   register takes one more item, and req.ready then drops until rsp moves.
//   Reset: all LEDs off, no channel blinking, timers and intervals cleared,
//   both registers empty.
`default_nettype none

module four_channel_led_blinker_core
    import ledblk_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ledblk_req_if.sink   req,
    ledblk_rsp_if.source rsp
);

    logic                in_valid_reg, in_valid_next;
    ledblk_cmd_t         cmd_reg;
    logic [CHANNELS-1:0] mask_reg;
    logic                out_valid_reg, out_valid_next;
    logic [CHANNELS-1:0] led_bits_reg;

    logic                advance;
    logic                take;
    logic [CHANNELS-1:0] leds;
    logic [CHANNELS-1:0] leds_next;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.kind        <= req.kind;
            cmd_reg.level_on    <= req.level_on;
            cmd_reg.on_time_ms  <= req.on_time_ms;
            cmd_reg.off_time_ms <= req.off_time_ms;
            cmd_reg.cycle_count <= req.cycle_count;
            mask_reg            <= req.channel_mask;
        end
        if (advance)
        begin
            led_bits_reg <= leds_next;
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        ledblk_channel u_chan (
            .clk      (clk),
            .rst_n    (rst_n),
            .enable   (advance),
            .sel      (mask_reg[i]),
            .cmd      (cmd_reg),
            .led      (leds[i]),
            .led_next (leds_next[i])
        );
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.led_bits = led_bits_reg;

    // result register always fills after an advance
    a_adv_fill: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

    // LEDs change only when an item is applied
    a_led_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(leds))
        else $error("LED state moved without an item");

    // set level forces the selected LEDs
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg.kind == KIND_LEVEL) |=>
        ((leds & $past(mask_reg)) ==
         ($past(cmd_reg.level_on) ? $past(mask_reg) : '0)))
        else $error("set level did not reach the selected LEDs");

    // the published result matches the channel LEDs
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (led_bits_reg == leds))
        else $error("result register differs from LED state");

endmodule

`default_nettype wire
